[rtl/sbd_pkg.sv]
// Shared types and constants for the switch bank debouncer.
`timescale 1ns / 1ps

package sbd_pkg;

    localparam int SAMPLE_W     = 8;
    localparam int TICK_W       = 16;
    localparam int SEL_W        = 2;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int NUM_SWITCHES_DEF = 8;

    localparam logic [TICK_W-1:0]   RISE_TICKS_RST   = TICK_W'(20);
    localparam logic [TICK_W-1:0]   FALL_TICKS_RST   = TICK_W'(20);
    localparam logic [SEL_W-1:0]    EVENT_SELECT_RST = SEL_W'(2);
    localparam logic [SAMPLE_W-1:0] EVENT_ENABLE_RST = '0;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RISE_TICKS   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FALL_TICKS   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_EVENT_SELECT = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_EVENT_ENABLE = CFG_INDEX_W'(3);

    // edge selection codes
    localparam logic [SEL_W-1:0] EVSEL_RISE = SEL_W'(0);
    localparam logic [SEL_W-1:0] EVSEL_FALL = SEL_W'(1);
    localparam logic [SEL_W-1:0] EVSEL_BOTH = SEL_W'(2);

    // input modes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] sample_bits;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] stable_bits;
        logic [SAMPLE_W-1:0] rose_bits;
        logic [SAMPLE_W-1:0] fell_bits;
        logic [SAMPLE_W-1:0] event_bits;
    } out_item_t;

    typedef struct packed {
        logic level;
        logic rose;
        logic fell;
    } lane_res_t;

endpackage

[rtl/sbd_lane.sv]
// One debounce lane: rise/fall counters and the stable level of one switch.
`timescale 1ns / 1ps

module sbd_lane
    import sbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              mode,
    input  logic              raw,
    input  logic [TICK_W-1:0] rise_ticks,
    input  logic [TICK_W-1:0] fall_ticks,
    output lane_res_t         res
);

    logic              level_reg, level_next;
    logic [TICK_W-1:0] rise_cnt_reg, rise_cnt_next;
    logic [TICK_W-1:0] fall_cnt_reg, fall_cnt_next;

    always_comb
    begin
        level_next    = level_reg;
        rise_cnt_next = rise_cnt_reg;
        fall_cnt_next = fall_cnt_reg;
        res.rose      = 1'b0;
        res.fell      = 1'b0;
        if (mode == MODE_LOAD || raw == level_reg)
        begin
            if (mode == MODE_LOAD)
            begin
                level_next = raw;
            end
            rise_cnt_next = rise_ticks;
            fall_cnt_next = fall_ticks;
        end
        else if (!level_reg)
        begin
            if (rise_cnt_reg == '0)
            begin
                level_next    = 1'b1;
                rise_cnt_next = rise_ticks;
                res.rose      = 1'b1;
            end
            else
            begin
                rise_cnt_next = rise_cnt_reg - TICK_W'(1);
            end
        end
        else
        begin
            if (fall_cnt_reg == '0)
            begin
                level_next    = 1'b0;
                fall_cnt_next = fall_ticks;
                res.fell      = 1'b1;
            end
            else
            begin
                fall_cnt_next = fall_cnt_reg - TICK_W'(1);
            end
        end
        res.level = level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= 1'b0;
            rise_cnt_reg <= RISE_TICKS_RST;
            fall_cnt_reg <= FALL_TICKS_RST;
        end
        else if (accept)
        begin
            level_reg    <= level_next;
            rise_cnt_reg <= rise_cnt_next;
            fall_cnt_reg <= fall_cnt_next;
        end
    end

endmodule

[rtl/sbd_merge.sv]
// Merge stage: edge selection, enable mask and two-entry output buffer.
`timescale 1ns / 1ps

module sbd_merge
    import sbd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [SAMPLE_W-1:0] stable_bits,
    input  logic [SAMPLE_W-1:0] rose_bits,
    input  logic [SAMPLE_W-1:0] fell_bits,
    input  logic [SEL_W-1:0]    event_select,
    input  logic [SAMPLE_W-1:0] event_enable,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_data
);

    out_item_t merged;
    out_item_t main_reg;
    out_item_t skid_reg;
    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    logic      out_take;
    logic      load_main;
    logic      load_skid;
    logic      move_skid;

    always_comb
    begin
        merged.stable_bits = stable_bits;
        merged.rose_bits   = rose_bits;
        merged.fell_bits   = fell_bits;
        merged.event_bits  = ((event_select != EVSEL_FALL) ? rose_bits : '0)
                           | ((event_select != EVSEL_RISE) ? fell_bits : '0);
        merged.event_bits  = merged.event_bits & event_enable;
    end

    assign out_take = main_valid_reg && !out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_main       = 1'b0;
        load_skid       = 1'b0;
        move_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                move_skid       = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!main_valid_reg || out_take)
            begin
                load_main       = 1'b1;
                main_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_main)
        begin
            main_reg <= merged;
        end
        else if (move_skid)
        begin
            main_reg <= skid_reg;
        end
        if (load_skid)
        begin
            skid_reg <= merged;
        end
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without a main entry");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !accept)
        else $error("transaction accepted with both buffer entries full");

    a_stalled_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && out_stall) |=> (main_valid_reg && $stable(main_reg)))
        else $error("stalled result dropped or changed");

    a_event_from_edge: assert property (@(posedge clk) disable iff (!rst_n)
        main_valid_reg |->
            ((main_reg.event_bits & ~(main_reg.rose_bits | main_reg.fell_bits)) == '0))
        else $error("event without an accepted edge");

    a_single_edge: assert property (@(posedge clk) disable iff (!rst_n)
        main_valid_reg |-> ((main_reg.rose_bits & main_reg.fell_bits) == '0))
        else $error("lane reports both edges in one transaction");

endmodule

[rtl/switch_bank_debouncer_top.sv]
// Top level of the switch bank debouncer: config registers, lanes and merge stage.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | in_data: mode, sample_bits
//  out      | out_valid / out_stall| out_data: stable/rose/fell/event bits
//  cfg      | cfg_write            | cfg_index, cfg_data
//
//  One transaction per clock while in_stall is low; its result is registered in the output buffer.
//  Every lane updates its counters in the cycle of acceptance, so throughput is
//  set by the two-entry output buffer only: full rate while out_stall stays low.
//  Reset is asynchronous, active low; counters load 20, levels clear.
//  in_stall rises only when both output entries hold unread results.
`timescale 1ns / 1ps

module switch_bank_debouncer_top
    import sbd_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ACTIVE_LANES = (NUM_SWITCHES < SAMPLE_W) ? NUM_SWITCHES : SAMPLE_W;

    logic [TICK_W-1:0]   rise_ticks_reg;
    logic [TICK_W-1:0]   fall_ticks_reg;
    logic [SEL_W-1:0]    event_select_reg;
    logic [SAMPLE_W-1:0] event_enable_reg;

    logic                accept;
    logic [SAMPLE_W-1:0] stable_bits;
    logic [SAMPLE_W-1:0] rose_bits;
    logic [SAMPLE_W-1:0] fell_bits;
    lane_res_t           lane_res [ACTIVE_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_ticks_reg   <= RISE_TICKS_RST;
            fall_ticks_reg   <= FALL_TICKS_RST;
            event_select_reg <= EVENT_SELECT_RST;
            event_enable_reg <= EVENT_ENABLE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RISE_TICKS:   rise_ticks_reg   <= cfg_data[TICK_W-1:0];
                REG_FALL_TICKS:   fall_ticks_reg   <= cfg_data[TICK_W-1:0];
                REG_EVENT_SELECT: event_select_reg <= cfg_data[SEL_W-1:0];
                REG_EVENT_ENABLE: event_enable_reg <= cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = in_valid && !in_stall;

    for (genvar g = 0; g < SAMPLE_W; g++)
    begin : g_lane
        if (g < ACTIVE_LANES)
        begin : g_on
            sbd_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .accept     (accept),
                .mode       (in_data.mode),
                .raw        (in_data.sample_bits[g]),
                .rise_ticks (rise_ticks_reg),
                .fall_ticks (fall_ticks_reg),
                .res        (lane_res[g])
            );
            assign stable_bits[g] = lane_res[g].level;
            assign rose_bits[g]   = lane_res[g].rose;
            assign fell_bits[g]   = lane_res[g].fell;
        end
        else
        begin : g_off
            assign stable_bits[g] = 1'b0;
            assign rose_bits[g]   = 1'b0;
            assign fell_bits[g]   = 1'b0;
        end
    end

    sbd_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .stable_bits  (stable_bits),
        .rose_bits    (rose_bits),
        .fell_bits    (fell_bits),
        .event_select (event_select_reg),
        .event_enable (event_enable_reg),
        .in_stall     (in_stall),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

endmodule

[test/switch_bank_debouncer_top_tb.sv]
// Testbench for switch_bank_debouncer_top: queued tick driver, debounce predictor and checker.
`timescale 1ns / 1ps

module switch_bank_debouncer_top_tb;
    import sbd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 1150;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_RISE_TICKS;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor state and register copies
    logic [TICK_W-1:0]   rise_ticks_m;
    logic [TICK_W-1:0]   fall_ticks_m;
    logic [SEL_W-1:0]    edge_sel_m;
    logic [SAMPLE_W-1:0] lane_en_m;
    logic [SAMPLE_W-1:0] level_m;
    logic [TICK_W-1:0]   rise_left [SAMPLE_W];
    logic [TICK_W-1:0]   fall_left [SAMPLE_W];

    in_item_t  tick_queue [$];
    out_item_t expected_out [$];
    out_item_t oldest_result;

    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    int   send_wait    = 0;
    int   recv_wait    = 0;
    bit   send_burst   = 1'b0;
    bit   recv_burst   = 1'b0;
    int   mismatches   = 0;
    int   quiet_cycles = 0;
    int   queued_items = 0;

    switch_bank_debouncer_top i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait(bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_ticks();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom_range(0, 65535));
            default: return CFG_DATA_W'($urandom_range(0, 4));
        endcase
    endfunction

    function automatic out_item_t debounce_step(in_item_t item);
        out_item_t           res;
        logic [SAMPLE_W-1:0] rose;
        logic [SAMPLE_W-1:0] fell;
        logic [SAMPLE_W-1:0] evt;
        rose = '0;
        fell = '0;
        if (item.mode == MODE_LOAD)
        begin
            level_m = item.sample_bits;
            for (int i = 0; i < SAMPLE_W; i++)
            begin
                rise_left[i] = rise_ticks_m;
                fall_left[i] = fall_ticks_m;
            end
        end
        else
        begin
            for (int i = 0; i < SAMPLE_W; i++)
            begin
                if (item.sample_bits[i] == level_m[i])
                begin
                    rise_left[i] = rise_ticks_m;
                    fall_left[i] = fall_ticks_m;
                end
                else if (!level_m[i])
                begin
                    if (rise_left[i] == '0)
                    begin
                        level_m[i]   = 1'b1;
                        rise_left[i] = rise_ticks_m;
                        rose[i]      = 1'b1;
                    end
                    else
                        rise_left[i] = rise_left[i] - 1'b1;
                end
                else
                begin
                    if (fall_left[i] == '0)
                    begin
                        level_m[i]   = 1'b0;
                        fall_left[i] = fall_ticks_m;
                        fell[i]      = 1'b1;
                    end
                    else
                        fall_left[i] = fall_left[i] - 1'b1;
                end
            end
        end
        evt = '0;
        if (edge_sel_m != EVSEL_FALL)
            evt |= rose;
        if (edge_sel_m != EVSEL_RISE)
            evt |= fell;
        res.stable_bits = level_m;
        res.rose_bits   = rose;
        res.fell_bits   = fell;
        res.event_bits  = evt & lane_en_m;
        return res;
    endfunction

    task automatic report_field(string name, logic [SAMPLE_W-1:0] exp_v,
                                logic [SAMPLE_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %h, actual %h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // driver: one transaction per queued tick, random gap after each
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_fire)
        begin
        end
        else if (send_wait > 0)
        begin
            in_valid <= 1'b0;
            send_wait--;
        end
        else if (tick_queue.size() > 0)
        begin
            in_data   <= tick_queue.pop_front();
            in_valid  <= 1'b1;
            send_wait = draw_wait(send_burst);
        end
        else
            in_valid <= 1'b0;
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (out_fire)
            recv_wait = draw_wait(recv_burst);
        if (recv_wait > 0)
        begin
            out_stall <= 1'b1;
            recv_wait--;
        end
        else
            out_stall <= 1'b0;
    end

    // monitor, predictor hook and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("unexpected transaction: %h", out_data);
                    mismatches++;
                end
                else
                begin
                    oldest_result = expected_out.pop_front();
                    report_field("stable_bits", oldest_result.stable_bits, out_data.stable_bits);
                    report_field("rose_bits", oldest_result.rose_bits, out_data.rose_bits);
                    report_field("fell_bits", oldest_result.fell_bits, out_data.fell_bits);
                    report_field("event_bits", oldest_result.event_bits, out_data.event_bits);
                end
            end
            if (in_valid && !in_stall)
                expected_out.push_back(debounce_step(in_data));
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
        in_fire  <= rst_n && in_valid && !in_stall;
        out_fire <= rst_n && out_valid && !out_stall;
    end

    task automatic push_tick(logic mode, logic [SAMPLE_W-1:0] bits);
        in_item_t item;
        item.mode        = mode;
        item.sample_bits = bits;
        tick_queue.push_back(item);
        queued_items++;
    endtask

    // held level with optional contact bounce
    task automatic push_run(logic [SAMPLE_W-1:0] level, int len, bit bounce);
        logic [SAMPLE_W-1:0] bits;
        for (int n = 0; n < len; n++)
        begin
            bits = level;
            if (bounce && $urandom_range(0, 7) == 0)
                bits[$urandom_range(0, SAMPLE_W-1)] ^= 1'b1;
            push_tick(MODE_TICK, bits);
        end
    endtask

    task automatic wait_quiet();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (tick_queue.size() != 0 || expected_out.size() != 0 || in_valid);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_RISE_TICKS:   rise_ticks_m = val;
            REG_FALL_TICKS:   fall_ticks_m = val;
            REG_EVENT_SELECT: edge_sel_m   = val[SEL_W-1:0];
            REG_EVENT_ENABLE: lane_en_m    = val[SAMPLE_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_config(logic [CFG_DATA_W-1:0] rise, logic [CFG_DATA_W-1:0] fall,
                                logic [CFG_DATA_W-1:0] sel, logic [CFG_DATA_W-1:0] en);
        wait_quiet();
        write_reg(REG_RISE_TICKS, rise);
        write_reg(REG_FALL_TICKS, fall);
        write_reg(REG_EVENT_SELECT, sel);
        write_reg(REG_EVENT_ENABLE, en);
    endtask

    initial
    begin
        int                  start_items;
        int                  phase_end;
        int                  span;
        logic [SAMPLE_W-1:0] level;

        rise_ticks_m = RISE_TICKS_RST;
        fall_ticks_m = FALL_TICKS_RST;
        edge_sel_m   = EVENT_SELECT_RST;
        lane_en_m    = EVENT_ENABLE_RST;
        level_m      = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            rise_left[i] = RISE_TICKS_RST;
            fall_left[i] = FALL_TICKS_RST;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: counters far from zero, events masked
        push_tick(MODE_TICK, 8'hFF);
        push_tick(MODE_TICK, 8'hFF);
        push_tick(MODE_LOAD, 8'hA5);
        push_tick(MODE_TICK, 8'h00);
        push_tick(MODE_TICK, 8'hFF);

        // new counts wait for a reload; unused select code passes both edges
        write_config(16'd0, 16'd1, 16'd3, 16'hFF);
        push_tick(MODE_TICK, 8'h5A);
        push_tick(MODE_LOAD, 8'h00);
        push_tick(MODE_TICK, 8'hFF);
        push_tick(MODE_TICK, 8'h00);
        push_tick(MODE_TICK, 8'h00);
        push_tick(MODE_TICK, 8'h0F);
        push_tick(MODE_TICK, 8'h0F);

        write_config(16'd0, 16'd1, CFG_DATA_W'(EVSEL_RISE), 16'h3C);
        push_tick(MODE_TICK, 8'hF0);
        push_tick(MODE_TICK, 8'hF0);
        push_tick(MODE_TICK, 8'hFF);

        write_config(16'hFFFF, 16'd0, CFG_DATA_W'(EVSEL_FALL), 16'hA5);
        push_tick(MODE_LOAD, 8'hFF);
        push_tick(MODE_TICK, 8'h00);
        push_tick(MODE_TICK, 8'hFF);

        start_items = queued_items;
        level = '0;
        while (queued_items - start_items < RANDOM_ITEMS)
        begin
            write_config(pick_ticks(), pick_ticks(), CFG_DATA_W'($urandom_range(0, 3)),
                         CFG_DATA_W'($urandom_range(0, 255)));
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            span = (rise_ticks_m > fall_ticks_m) ? rise_ticks_m : fall_ticks_m;
            if (span > 36)
                span = 36;
            phase_end = queued_items + $urandom_range(30, 60);
            if ($urandom_range(0, 1) == 0)
                push_tick(MODE_LOAD, SAMPLE_W'($urandom_range(0, 255)));
            while (queued_items < phase_end)
            begin
                case ($urandom_range(0, 9))
                    0: push_tick(MODE_TICK, SAMPLE_W'($urandom_range(0, 255)));
                    1: push_tick(MODE_LOAD, SAMPLE_W'($urandom_range(0, 255)));
                    default:
                    begin
                        if ($urandom_range(0, 1) == 0)
                            level = SAMPLE_W'($urandom_range(0, 255));
                        else
                            level[$urandom_range(0, SAMPLE_W-1)] ^= 1'b1;
                        push_run(level, $urandom_range(1, span + 3), $urandom_range(0, 2) == 0);
                    end
                endcase
            end
        end

        wait_quiet();
        repeat (4) @(posedge clk);
        #1;
        if (mismatches == 0 && expected_out.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
